@@ src/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Types and constants shared by the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] MISS_DATA = {DATA_W{1'b1}};

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                    go;
    logic                    hit;
    logic                    put;
    logic signed [KEY_W-1:0] key;
  } lkv_ctl_t;

endpackage

`default_nettype wire

@@ src/lkv_if.sv @@
// ----------------------------------------------------------------------------
// lkv_if
// Request, response and configuration channels of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkv_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [lkv_pkg::KEY_W-1:0]   key;
  logic signed [lkv_pkg::DATA_W-1:0]  value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [lkv_pkg::DATA_W-1:0]  data;

  modport source (output valid, output found, output data, input ready);
  modport sink   (input valid, input found, input data, output ready);
endinterface

interface lkv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lkv_pkg::CAP_W-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/lkv_cell.sv @@
// ----------------------------------------------------------------------------
// lkv_cell
// One slot of the recency chain: key, data and valid, with the match logic
// and a one-step shift from the neighbouring, more recent slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lkv_pkg::lkv_ctl_t                 ctl,
  input  wire logic [CW-1:0]                     used_eff,
  input  wire logic signed [lkv_pkg::KEY_W-1:0]  prev_key,
  input  wire logic signed [lkv_pkg::DATA_W-1:0] prev_data,
  input  wire logic                              prev_valid,
  input  wire logic                              hit_in,
  input  wire logic [lkv_pkg::DATA_W-1:0]        data_in,
  output logic signed [lkv_pkg::KEY_W-1:0]       key,
  output logic signed [lkv_pkg::DATA_W-1:0]      data,
  output logic                                   valid,
  output logic                                   hit_out,
  output logic [lkv_pkg::DATA_W-1:0]             data_out
);
  import lkv_pkg::*;

  logic matched;
  logic sel;
  logic in_range;
  logic shift;
  logic drop;

  always_comb begin
    matched  = valid && (key == ctl.key);
    sel      = matched && !hit_in;
    hit_out  = hit_in || matched;
    data_out = data_in | (sel ? DATA_W'(data) : '0);
    in_range = (CW'(IDX) <= used_eff);
    shift    = ctl.hit ? !hit_in : (ctl.put && in_range);
    drop     = !ctl.hit && ctl.put && !in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.go) begin
      if (shift) begin
        valid <= prev_valid;
      end else if (drop) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && shift) begin
      key  <= prev_key;
      data <= prev_data;
    end
  end

endmodule

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache kept in recency order by a chain of cells.
// ----------------------------------------------------------------------------
//   channel  dir  fields
//   req      in   cmd, key, value
//   rsp      out  found, data (one item per get, none per put)
//   cfg      in   capacity
//
// One item per cycle: every slot compares its key in parallel and the chain
// shifts one step in the same cycle; the first-match ripple sets the path.
// Reset clears every valid bit and the fill count at once; no clearing pass.
// A stalled response holds in its output register; req stalls only while it
// is full and not being taken. cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  lkv_req_if.sink   req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink   cfg
);
  import lkv_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    used_count;
  logic [CW-1:0]    used_next;
  logic [CW-1:0]    lim;
  logic [CW-1:0]    used_eff;
  logic [LW-1:0]    cap_ext;

  logic                     accept;
  lkv_ctl_t                 ctl;
  logic signed [DATA_W-1:0] front_data;
  logic                     hit;

  logic signed [KEY_W-1:0]  cell_key   [ENTRIES];
  logic signed [DATA_W-1:0] cell_data  [ENTRIES];
  logic [ENTRIES-1:0]       cell_valid;
  logic [ENTRIES:0]         hit_chain;
  logic [DATA_W-1:0]        data_chain [ENTRIES+1];

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    cap_ext = LW'(capacity);
    if (capacity == '0) begin
      lim = CW'(1);
    end else if (cap_ext > LW'(ENTRIES)) begin
      lim = CW'(ENTRIES);
    end else begin
      lim = CW'(cap_ext);
    end
    used_eff  = (used_count >= lim) ? (lim - CW'(1)) : used_count;
    used_next = used_eff + CW'(1);
  end

  assign hit_chain[0]  = 1'b0;
  assign data_chain[0] = '0;
  assign hit           = hit_chain[ENTRIES];

  always_comb begin
    ctl.go     = accept;
    ctl.hit    = hit;
    ctl.put    = (req.cmd == CMD_PUT);
    ctl.key    = req.key;
    front_data = (req.cmd == CMD_GET) ? DATA_W'(data_chain[ENTRIES]) : req.value;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      lkv_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .used_eff   (used_eff),
        .prev_key   (req.key),
        .prev_data  (front_data),
        .prev_valid (1'b1),
        .hit_in     (hit_chain[i]),
        .data_in    (data_chain[i]),
        .key        (cell_key[i]),
        .data       (cell_data[i]),
        .valid      (cell_valid[i]),
        .hit_out    (hit_chain[i+1]),
        .data_out   (data_chain[i+1])
      );
    end else begin : g_body
      lkv_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .used_eff   (used_eff),
        .prev_key   (cell_key[i-1]),
        .prev_data  (cell_data[i-1]),
        .prev_valid (cell_valid[i-1]),
        .hit_in     (hit_chain[i]),
        .data_in    (data_chain[i]),
        .key        (cell_key[i]),
        .data       (cell_data[i]),
        .valid      (cell_valid[i]),
        .hit_out    (hit_chain[i+1]),
        .data_out   (data_chain[i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      used_count <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.data;
      end
      if (accept && req.cmd == CMD_PUT && !hit) begin
        used_count <= used_next;
      end
      if (accept && req.cmd == CMD_GET) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.cmd == CMD_GET) begin
      rsp.found <= hit;
      rsp.data  <= hit ? DATA_W'(data_chain[ENTRIES]) : MISS_DATA;
    end
  end

  a_fill_matches_valid : assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(used_count))
    else $error("fill count disagrees with valid slots");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(ENTRIES))
    else $error("fill count above slot count");

  a_get_answers : assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_GET) |=> rsp.valid)
    else $error("get item gave no response");

  a_put_silent : assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == CMD_PUT) |=> !rsp.valid)
    else $error("put item gave a response");

endmodule

`default_nettype wire

@@ tb/sv/lru_cache_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_cache_checker
// Watches the request, response and capacity channels of the LRU key-value
// cache, keeps its own recency-ordered copy of the entries and compares every
// lookup response, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lru_cache_checker #(
  parameter int SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  lkv_req_if        req,
  lkv_rsp_if        rsp,
  lkv_cfg_if        cfg,
  output int        errors,
  output int        waiting,
  output int        hits
);
  import lkv_pkg::*;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] data;
  } lookup_t;

  logic [KEY_W-1:0]  held_key  [SLOTS];
  logic [DATA_W-1:0] held_data [SLOTS];
  bit                held_valid [SLOTS];
  int unsigned       fill;
  logic [CAP_W-1:0]  cap_reg;
  lookup_t           lookups_due [$];
  int                fails = 0;
  int                hit_count = 0;

  assign errors = fails;
  assign hits   = hit_count;

  function automatic int unsigned cap_limit();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function automatic int unsigned locate(input logic [KEY_W-1:0] k);
    for (int unsigned i = 0; i < fill && i < SLOTS; i++)
      if (held_valid[i] && held_key[i] == k) return i;
    return SLOTS;
  endfunction

  task automatic move_to_front(input int unsigned pos, input logic [KEY_W-1:0] k,
                               input logic [DATA_W-1:0] d);
    int unsigned p;
    p = (pos >= SLOTS) ? SLOTS - 1 : pos;
    for (int unsigned j = p; j > 0; j--) begin
      held_key[j]   = held_key[j-1];
      held_data[j]  = held_data[j-1];
      held_valid[j] = held_valid[j-1];
    end
    held_key[0]   = k;
    held_data[0]  = d;
    held_valid[0] = 1'b1;
  endtask

  task automatic serve(input logic op, input logic [KEY_W-1:0] k,
                       input logic [DATA_W-1:0] v);
    int unsigned pos;
    int unsigned lim;
    logic [DATA_W-1:0] d;
    pos = locate(k);
    if (op == CMD_GET) begin
      if (pos < SLOTS) begin
        d = held_data[pos];
        lookups_due.push_back('{1'b1, d});
        hit_count++;
        move_to_front(pos, k, d);
      end else begin
        lookups_due.push_back('{1'b0, MISS_DATA});
      end
    end else if (pos < SLOTS) begin
      move_to_front(pos, k, v);
    end else begin
      lim = cap_limit();
      if (fill >= lim) begin
        fill = lim - 1;
        for (int unsigned i = fill; i < SLOTS; i++) held_valid[i] = 1'b0;
      end
      move_to_front(fill, k, v);
      fill++;
    end
  endtask

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) held_valid[i] = 1'b0;
      fill = 0;
      cap_reg = CAP_RESET;
      lookups_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (lookups_due.size() == 0) begin
          fails++;
          $display("%0t  unexpected response: found %0b data %h",
                   $time, rsp.found, rsp.data);
        end else begin
          want = lookups_due.pop_front();
          if (rsp.found !== want.found) begin
            fails++;
            $display("%0t  found: expected %0b, actual %0b", $time, want.found, rsp.found);
          end
          if (rsp.data !== want.data) begin
            fails++;
            $display("%0t  data: expected %h, actual %h", $time, want.data, rsp.data);
          end
        end
      end
      if (cfg.valid && cfg.ready) cap_reg = cfg.data;
      if (req.valid && req.ready) serve(req.cmd, req.key, req.value);
    end
    waiting <= lookups_due.size();
  end

endmodule

@@ tb/sv/lru_key_value_cache_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test
// Drives gets and puts into the LRU key-value cache across a range of capacity
// settings, with random idling on both channels and one long response stall;
// the checker beside the block predicts and compares every lookup.
// ----------------------------------------------------------------------------
module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int RSP_HOLD    = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 128;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkv_req_if req ();
  lkv_rsp_if rsp ();
  lkv_cfg_if cfg ();

  int errors;
  int waiting;
  int hits;
  bit idling   = 1'b1;
  bit rsp_hold = 1'b0;
  int sent     = 0;
  int gets     = 0;
  int settings = 0;
  int quiet    = 0;

  logic [KEY_W-1:0] pool [32];
  logic [CAP_W-1:0] caps [PHASES];

  always #1 clk = ~clk;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  lru_cache_checker #(.SLOTS(ENTRIES)) cache_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .errors  (errors),
    .waiting (waiting),
    .hits    (hits)
  );

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic offer(input logic op, input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] v);
    req.cmd   <= op;
    req.key   <= k;
    req.value <= v;
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    sent++;
    if (op == CMD_GET) gets++;
    if (idling && $urandom_range(0, 2) == 0) begin
      req.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    cfg.data  <= c;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    settings++;
  endtask

  task automatic random_item(input int span);
    logic [KEY_W-1:0] k;
    logic op;
    k  = ($urandom_range(0, 9) == 0) ? rand_word() : pool[$urandom_range(0, span - 1)];
    op = ($urandom_range(0, 9) < 5) ? CMD_GET : CMD_PUT;
    offer(op, k, rand_word());
  endtask

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("lru_key_value_cache: mismatch");
      $finish;
    end
  end

  initial begin
    bit long_done;
    long_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold && !long_done) begin
        rsp.ready <= 1'b0;
        repeat (RSP_HOLD) @(posedge clk);
        long_done = 1'b1;
        rsp.ready <= 1'b1;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned eff;
    int span;
    req.valid = 1'b0;
    req.cmd   = CMD_GET;
    req.key   = '0;
    req.value = '0;
    cfg.valid = 1'b0;
    cfg.data  = CAP_RESET;
    caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd17, 5'd8, 5'd2, 5'd15, 5'd5, 5'd12, 5'd16};
    caps[PHASES-1] = CAP_W'($urandom_range(0, 31));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty cache, extremes of key and value, update in place
    offer(CMD_GET, 32'h0000_0000, 32'h1234_5678);
    offer(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
    offer(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
    offer(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
    offer(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    offer(CMD_GET, 32'h8000_0000, 32'h0);
    offer(CMD_GET, 32'hffff_ffff, 32'h0);
    offer(CMD_GET, 32'h0000_0005, 32'h0);
    offer(CMD_PUT, 32'h7fff_ffff, 32'd123);
    offer(CMD_GET, 32'h7fff_ffff, 32'h0);

    // shrink below the fill: lookups still see everything until a new key lands
    settle();
    set_capacity(5'd2);
    offer(CMD_GET, 32'h0000_0000, 32'h0);
    offer(CMD_PUT, 32'd77, 32'd1);
    offer(CMD_GET, 32'hffff_ffff, 32'h0);
    offer(CMD_GET, 32'h0000_0000, 32'h0);
    offer(CMD_PUT, 32'd88, 32'd2);
    offer(CMD_GET, 32'd77, 32'h0);

    // zero capacity holds one entry
    settle();
    set_capacity(5'd0);
    offer(CMD_PUT, 32'd99, 32'd3);
    offer(CMD_GET, 32'h0000_0000, 32'h0);
    offer(CMD_GET, 32'd99, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_capacity(caps[p]);
      eff = caps[p];
      if (eff < 1) eff = 1;
      if (eff > ENTRIES) eff = ENTRIES;
      span = eff + $urandom_range(1, 4);
      for (int i = 0; i < span; i++) pool[i] = rand_word();
      idling = (p % 4 != 3);
      if (p == 1) begin
        // stall the response side and keep offering lookups
        rsp_hold = 1'b1;
        for (int i = 0; i < 40; i++) offer(CMD_GET, pool[$urandom_range(0, span - 1)], $urandom());
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) settle();
        random_item(span);
      end
    end

    idling = 1'b1;
    settle();
    $display("%0d requests sent, %0d lookups (%0d hits), over %0d capacity settings",
             sent, gets, hits, settings);
    if (errors == 0 && waiting == 0)
      $display("lru_key_value_cache: match");
    else
      $display("lru_key_value_cache: mismatch");
    $finish;
  end

endmodule
